// File: sv/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset
`define UTSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked during reset too
`define UTSP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/utsp_pkg.sv
// package of the u-turn twin-sine planner: constants, types and step functions
package utsp_pkg;

  localparam int TIME_BITS  = 16;
  localparam int DIV_STEPS  = 36;
  localparam int SQRT_STEPS = 18;
  localparam int Q_DEPTH    = 4;
  localparam int Q_AW       = $clog2(Q_DEPTH);

  localparam logic [36:0] T_MAX       = 37'((37'd1 << TIME_BITS) - 37'd1);
  localparam logic [30:0] PI_Q29      = 31'h6487ED51;
  localparam logic [30:0] OS_K_Q32    = 31'd1508912994;
  localparam logic [31:0] ACCEL_RESET = 32'h0001_0000;
  localparam logic [31:0] JERK_RESET  = 32'h0001_0000;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_VEL = 2'd1,
    ST_ZERO_LIM = 2'd2,
    ST_TIME_SAT = 2'd3
  } stat_t;

  typedef enum logic {
    REG_ACCEL_LIMIT = 1'b0,
    REG_JERK_LIMIT  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic        neg;
    logic [31:0] vm;
    stat_t       st;
  } cm_t;

  typedef struct packed {
    cm_t         cm;
    logic [31:0] am;
    logic [31:0] jm;
    logic [35:0] numa;
    logic [35:0] numj;
  } fe_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [35:0] n;
  } dv_t;

  typedef struct packed {
    logic [35:0] x;
    logic [19:0] rem;
    logic [17:0] root;
  } sq_t;

  typedef struct packed {
    cm_t         cm;
    logic [31:0] am;
    logic [31:0] jm;
    dv_t         da;
    dv_t         dj;
  } p1_t;

  typedef struct packed {
    cm_t         cm;
    logic [35:0] ta;
    sq_t         sq;
  } p2_t;

  typedef struct packed {
    cm_t                  cm;
    logic [TIME_BITS-1:0] t;
    logic [63:0]          a;
    logic [63:0]          b;
  } pm_t;

  typedef struct packed {
    cm_t                  cm;
    logic [TIME_BITS-1:0] t;
    logic [63:0]          dm;
    logic [35:0]          aq;
    logic [28:0]          lo29;
    dv_t                  d;
  } p3_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] dec_time;
    logic [31:0]          accel_peak;
    logic [31:0]          jerk_peak;
    logic [63:0]          overshoot_dist;
    logic [31:0]          speed_peak;
    logic [32:0]          end_velocity;
    stat_t                status;
  } ob_t;

  function automatic logic [31:0] mag32(input logic [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

  // one restoring division step, quotient bits shift in at the bottom of n
  function automatic dv_t div_step(input dv_t s, input logic [31:0] den);
    dv_t         r;
    logic [32:0] tr;
    tr = {s.rem, s.n[35]};
    if (tr >= {1'b0, den}) begin
      r.rem = 32'(tr - {1'b0, den});
      r.n   = {s.n[34:0], 1'b1};
    end else begin
      r.rem = tr[31:0];
      r.n   = {s.n[34:0], 1'b0};
    end
    return r;
  endfunction

  // one digit-by-digit square root step
  function automatic sq_t sqrt_step(input sq_t s);
    sq_t         r;
    logic [19:0] r4;
    logic [19:0] trial;
    r4    = {s.rem[17:0], s.x[35:34]};
    trial = {s.root, 2'b01};
    r.x   = {s.x[33:0], 2'b00};
    if (r4 >= trial) begin
      r.rem  = r4 - trial;
      r.root = {s.root[16:0], 1'b1};
    end else begin
      r.rem  = r4;
      r.root = {s.root[16:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [31:0] sat32(input logic neg, input logic [35:0] m);
    if (neg) begin
      if (m >= 36'h0_8000_0000) return 32'h8000_0000;
      return 32'(36'd0 - m);
    end
    if (m > 36'h0_7FFF_FFFF) return 32'h7FFF_FFFF;
    return m[31:0];
  endfunction

endpackage

// File: sv/uturn_twin_sine_profile_plan.sv
// top level of the u-turn twin-sine move planner
//
// Input channel: in_valid/in_ready with start_velocity, signed Q16.16.
// Output channel: out_valid/out_ready with dec_time, accel_peak, jerk_peak,
// overshoot_dist, speed_peak, end_velocity and status, one result per input.
// Limits: cfg_write with cfg_index 0 (accel_limit) or 1 (jerk_limit) and
// cfg_data; write them only while no velocity is in flight.
// Throughput: one velocity per cycle while out_ready does not stall the
// output. A front register classifies each velocity and pushes it into a
// four-entry queue; the back pipeline runs two 36-step restoring dividers
// for the time bounds, an 18-step square root, a 36-step divider for the
// peak acceleration and another for the peak jerk.
// Reset: limits return to 1.0, queue and pipeline are emptied.
// Stall: when out_ready is low with a result waiting, the back pipeline
// holds, the queue fills, and in_ready drops once the front register is
// also occupied; no result is lost or repeated.
module uturn_twin_sine_profile_plan (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [31:0]                    start_velocity,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [utsp_pkg::TIME_BITS-1:0] dec_time,
  output logic [31:0]                    accel_peak,
  output logic [31:0]                    jerk_peak,
  output logic [63:0]                    overshoot_dist,
  output logic [31:0]                    speed_peak,
  output logic [32:0]                    end_velocity,
  output logic [1:0]                     status,
  input  logic                           cfg_write,
  input  logic                           cfg_index,
  input  logic [31:0]                    cfg_data
);
  import utsp_pkg::*;

  fe_t  entry;
  fe_t  head;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;

  utsp_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .start_velocity (start_velocity),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .q_full         (q_full),
    .push           (push),
    .entry          (entry)
  );

  utsp_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (entry),
    .pop   (pop),
    .rdata (head),
    .full  (q_full),
    .empty (q_empty)
  );

  utsp_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .dec_time       (dec_time),
    .accel_peak     (accel_peak),
    .jerk_peak      (jerk_peak),
    .overshoot_dist (overshoot_dist),
    .speed_peak     (speed_peak),
    .end_velocity   (end_velocity),
    .status         (status)
  );

endmodule

// File: sv/utsp_front.sv
// front end: limit registers, input register and classification of each velocity
module utsp_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [31:0]    start_velocity,
  input  logic           cfg_write,
  input  logic           cfg_index,
  input  logic [31:0]    cfg_data,
  input  logic           q_full,
  output logic           push,
  output utsp_pkg::fe_t  entry
);
  import utsp_pkg::*;

  logic        fv;
  logic [31:0] fvel;
  logic [31:0] accel_limit;
  logic [31:0] jerk_limit;
  logic [31:0] vm;
  logic [31:0] am;
  logic [31:0] jm;
  logic [62:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_limit <= ACCEL_RESET;
      jerk_limit  <= JERK_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ACCEL_LIMIT: accel_limit <= cfg_data;
        REG_JERK_LIMIT:  jerk_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = !fv || !q_full;
  assign push     = fv && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (in_ready) begin
      fv <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      fvel <= start_velocity;
    end
  end

  always_comb begin
    vm   = mag32(fvel);
    am   = mag32(accel_limit);
    jm   = mag32(jerk_limit);
    prod = {31'd0, vm} * {32'd0, PI_Q29};
    entry.cm.neg = fvel[31];
    entry.cm.vm  = vm;
    if (vm == 32'd0) begin
      entry.cm.st = ST_ZERO_VEL;
    end else if (am == 32'd0 || jm == 32'd0) begin
      entry.cm.st = ST_ZERO_LIM;
    end else begin
      entry.cm.st = ST_OK;
    end
    entry.am   = am;
    entry.jm   = jm;
    // ceil(4|v|/a) and ceil(4|v|pi/j) as numerators
    entry.numa = {2'b00, vm, 2'b00} + 36'(am) - 36'd1;
    entry.numj = 36'((prod + 63'((63'd1 << 27) - 63'd1)) >> 27) + 36'(jm) - 36'd1;
  end

endmodule

// File: sv/utsp_queue.sv
// short queue between the front end and the arithmetic pipeline
module utsp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  utsp_pkg::fe_t wdata,
  input  logic          pop,
  output utsp_pkg::fe_t rdata,
  output logic          full,
  output logic          empty
);
  import utsp_pkg::*;

  fe_t             mem [0:Q_DEPTH-1];
  logic [Q_AW-1:0] wp;
  logic [Q_AW-1:0] rp;
  logic [Q_AW:0]   cnt;

  assign full  = (cnt == (Q_AW+1)'(Q_DEPTH));
  assign empty = (cnt == '0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      unique case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wdata;
  end

endmodule

// File: sv/utsp_back.sv
// arithmetic pipeline: time from two divisions and a square root, then the peaks
module utsp_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_empty,
  input  utsp_pkg::fe_t                  head,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [utsp_pkg::TIME_BITS-1:0] dec_time,
  output logic [31:0]                    accel_peak,
  output logic [31:0]                    jerk_peak,
  output logic [63:0]                    overshoot_dist,
  output logic [31:0]                    speed_peak,
  output logic [32:0]                    end_velocity,
  output logic [1:0]                     status
);
  import utsp_pkg::*;

  logic adv;

  p1_t p1 [0:DIV_STEPS];
  p2_t p2 [0:SQRT_STEPS];
  pm_t st_t;
  pm_t st_p;
  pm_t st_k;
  p3_t p3 [0:DIV_STEPS];
  p3_t st_a;
  pm_t st_m;
  p3_t st_h;
  p3_t p4 [0:DIV_STEPS];
  ob_t ob;

  logic [DIV_STEPS:0]  v1;
  logic [SQRT_STEPS:0] v2;
  logic [2:0]          vmid;
  logic [DIV_STEPS:0]  v3;
  logic [1:0]          vaq;
  logic [DIV_STEPS:0]  v4;
  logic                ov;

  pm_t         tsel;
  logic [18:0] tj;
  logic [36:0] tt;
  ob_t         ob_next;
  logic [35:0] jq;
  logic        ok;
  logic [63:0] xw;

  assign adv = !ov || out_ready;
  assign pop = adv && !q_empty;

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= '0;
      v2   <= '0;
      vmid <= '0;
      v3   <= '0;
      vaq  <= '0;
      v4   <= '0;
      ov   <= 1'b0;
    end else if (adv) begin
      v1   <= {v1[DIV_STEPS-1:0], pop};
      v2   <= {v2[SQRT_STEPS-1:0], v1[DIV_STEPS]};
      vmid <= {vmid[1:0], v2[SQRT_STEPS]};
      v3   <= {v3[DIV_STEPS-1:0], vmid[2]};
      vaq  <= {vaq[0], v3[DIV_STEPS]};
      v4   <= {v4[DIV_STEPS-1:0], vaq[1]};
      ov   <= v4[DIV_STEPS];
    end
  end

  // time selection from ceil(4|v|/a) and the jerk bound
  always_comb begin
    tj = {1'b0, p2[SQRT_STEPS].sq.root} + 19'd1;
    tt = (37'(p2[SQRT_STEPS].ta) > 37'(tj)) ? 37'(p2[SQRT_STEPS].ta) : 37'(tj);
    tsel    = '0;
    tsel.cm = p2[SQRT_STEPS].cm;
    if (tt > T_MAX) begin
      tsel.t = T_MAX[TIME_BITS-1:0];
      if (p2[SQRT_STEPS].cm.st == ST_OK) tsel.cm.st = ST_TIME_SAT;
    end else begin
      tsel.t = tt[TIME_BITS-1:0];
    end
  end

  always_comb begin
    xw = (st_m.a << 18) + st_m.b;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1[0].cm    <= head.cm;
      p1[0].am    <= head.am;
      p1[0].jm    <= head.jm;
      p1[0].da    <= '{rem: 32'd0, n: head.numa};
      p1[0].dj    <= '{rem: 32'd0, n: head.numj};
      for (int k = 0; k < DIV_STEPS; k++) begin
        p1[k+1].cm <= p1[k].cm;
        p1[k+1].am <= p1[k].am;
        p1[k+1].jm <= p1[k].jm;
        p1[k+1].da <= div_step(p1[k].da, p1[k].am);
        p1[k+1].dj <= div_step(p1[k].dj, p1[k].jm);
      end

      // smallest t with t*t >= q is isqrt(q-1)+1
      p2[0].cm <= p1[DIV_STEPS].cm;
      p2[0].ta <= p1[DIV_STEPS].da.n;
      p2[0].sq <= '{x: p1[DIV_STEPS].dj.n - 36'd1, rem: 20'd0, root: 18'd0};
      for (int k = 0; k < SQRT_STEPS; k++) begin
        p2[k+1].cm <= p2[k].cm;
        p2[k+1].ta <= p2[k].ta;
        p2[k+1].sq <= sqrt_step(p2[k].sq);
      end

      st_t <= tsel;

      st_p   <= st_t;
      st_p.a <= 64'(st_t.cm.vm) * 64'(st_t.t);

      st_k   <= st_p;
      st_k.a <= 64'(st_p.a[63:32]) * 64'(OS_K_Q32);
      st_k.b <= 64'(st_p.a[31:0]) * 64'(OS_K_Q32);

      p3[0].cm   <= st_k.cm;
      p3[0].t    <= st_k.t;
      p3[0].dm   <= st_k.a + ((st_k.b + 64'h8000_0000) >> 32);
      p3[0].aq   <= '0;
      p3[0].lo29 <= '0;
      p3[0].d    <= '{rem: 32'd0, n: {2'b00, st_k.cm.vm, 2'b00}};
      for (int k = 0; k < DIV_STEPS; k++) begin
        p3[k+1]   <= p3[k];
        p3[k+1].d <= div_step(p3[k].d, 32'(p3[k].t));
      end

      st_a    <= p3[DIV_STEPS];
      st_a.aq <= p3[DIV_STEPS].d.n
               + 36'({p3[DIV_STEPS].d.rem, 1'b0} >= 33'(p3[DIV_STEPS].t));

      st_m.cm <= st_a.cm;
      st_m.t  <= st_a.t;
      st_m.a  <= 64'(st_a.aq[35:18]) * 64'(PI_Q29);
      st_m.b  <= 64'(st_a.aq[17:0]) * 64'(PI_Q29);
      st_h    <= st_a;

      p4[0]      <= st_h;
      p4[0].lo29 <= xw[28:0];
      p4[0].d    <= '{rem: 32'd0, n: 36'(xw[63:29])};
      for (int k = 0; k < DIV_STEPS; k++) begin
        p4[k+1]   <= p4[k];
        p4[k+1].d <= div_step(p4[k].d, 32'(p4[k].t));
      end

      ob <= ob_next;
    end
  end

  // aq and dm travel beside the jerk products in st_h
  p3_t tail;
  always_comb begin
    tail = p4[DIV_STEPS];
    jq   = tail.d.n + 36'({tail.d.rem, tail.lo29, 1'b0} >= 62'({32'(tail.t), 29'd0}));
    ok   = (tail.cm.st == ST_OK) || (tail.cm.st == ST_TIME_SAT);
    ob_next        = '0;
    ob_next.status = tail.cm.st;
    if (ok) begin
      ob_next.dec_time       = tail.t;
      ob_next.accel_peak     = sat32(!tail.cm.neg, tail.aq);
      ob_next.jerk_peak      = sat32(!tail.cm.neg, jq);
      ob_next.overshoot_dist = tail.cm.neg ? (64'd0 - tail.dm) : tail.dm;
      ob_next.speed_peak     = tail.cm.vm;
      ob_next.end_velocity   = tail.cm.neg ? {1'b0, tail.cm.vm}
                                           : (33'd0 - {1'b0, tail.cm.vm});
    end
  end

  assign out_valid      = ov;
  assign dec_time       = ob.dec_time;
  assign accel_peak     = ob.accel_peak;
  assign jerk_peak      = ob.jerk_peak;
  assign overshoot_dist = ob.overshoot_dist;
  assign speed_peak     = ob.speed_peak;
  assign end_velocity   = ob.end_velocity;
  assign status         = ob.status;

endmodule

// File: sv/utsp_check.sv
// port checker for the u-turn planner and its bind
`include "assert_macros.svh"

module utsp_check (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic [31:0]                    start_velocity,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [utsp_pkg::TIME_BITS-1:0] dec_time,
  input logic [31:0]                    accel_peak,
  input logic [31:0]                    jerk_peak,
  input logic [63:0]                    overshoot_dist,
  input logic [31:0]                    speed_peak,
  input logic [32:0]                    end_velocity,
  input logic [1:0]                     status,
  input logic                           cfg_write,
  input logic                           cfg_index,
  input logic [31:0]                    cfg_data
);
  import utsp_pkg::*;

  `UTSP_ASSERT_RST(a_rst_empty, rst |=> !out_valid, "result shown straight after reset")

  `UTSP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(overshoot_dist) && $stable(status), "stalled result changed")

  `UTSP_ASSERT(a_err_zero, out_valid && (status == ST_ZERO_VEL || status == ST_ZERO_LIM) |-> dec_time == '0 && accel_peak == '0 && jerk_peak == '0 && overshoot_dist == '0 && speed_peak == '0 && end_velocity == '0, "error result not cleared")

  `UTSP_ASSERT(a_sat_time, out_valid && status == ST_TIME_SAT |-> dec_time == T_MAX[TIME_BITS-1:0], "saturated time not at maximum")

  `UTSP_ASSERT(a_speed_end, out_valid && (status == ST_OK || status == ST_TIME_SAT) |-> speed_peak != '0 && dec_time != '0 && (end_velocity == 33'(speed_peak) || (end_velocity + 33'(speed_peak)) == 33'd0), "peak speed and end velocity disagree")

endmodule

bind uturn_twin_sine_profile_plan utsp_check u_check (.*);
